@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define DSDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression that must hold at every clock edge out of reset.
`define DSDC_ASSERT_ALWAYS(lbl, expr, msg) \
    `DSDC_ASSERT(lbl, 1'b1 |-> (expr), msg)

`endif

@@ src/dsdc_pkg.sv @@
package dsdc_pkg;

    localparam int CNT_W    = 30;
    localparam int DIGIT_W  = 4;
    localparam int WINDOW   = 10;

    localparam logic [CNT_W-1:0]   COUNT_PRIME = 30'd1000000007;
    localparam logic [DIGIT_W-1:0] TOP_DIGIT   = 4'd9;

    localparam logic [1:0] REG_MODULUS_ADDR = 2'd0;
    localparam logic [7:0] MODULUS_RESET    = 8'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_SWEEP,
        ST_OUT
    } state_t;

    // (a + b) mod P, both operands below P
    function automatic logic [CNT_W-1:0] add_mod(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, COUNT_PRIME})
        begin
            s = s - {1'b0, COUNT_PRIME};
        end
        return s[CNT_W-1:0];
    endfunction

    // (a - b) mod P, both operands below P
    function automatic logic [CNT_W-1:0] sub_mod(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (d[CNT_W])
        begin
            d = d + {1'b0, COUNT_PRIME};
        end
        return d[CNT_W-1:0];
    endfunction

endpackage

@@ src/dsdc_ram.sv @@
module dsdc_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/digit_sum_divisible_counter.sv @@
// Digit-sum divisibility counter, one decimal digit per transaction.
// Digits are taken one at a time: s_tready is high only in idle, so each digit's
//   sweep of m + 9 window reads (m = effective modulus) ends before the next is taken.
// Result: the count appears on m_tdata once the last digit's sweep ends, later
//   while an older count still waits for m_tready.
// Reset: rst_n is asynchronous, active low; modulus returns to 1, table and
//   tight residue read as zero, no transaction pending.
`include "assert_macros.svh"

module digit_sum_divisible_counter #(
    parameter int MAX_MODULUS = 128
) (
    input  logic        clk,
    input  logic        rst_n,

    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [3:0] digit, [7:4] zero
    input  logic        s_tlast,    // last_digit

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [29:0] count, [31:30] zero

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import dsdc_pkg::*;

    // MW holds the modulus itself, AW indexes residues 0..m-1,
    // CW counts the m + 9 reads of one sweep.
    localparam int MW = $clog2(MAX_MODULUS + 1);
    localparam int AW = (MAX_MODULUS > 1) ? $clog2(MAX_MODULUS) : 1;
    localparam int CW = $clog2(MAX_MODULUS + WINDOW);
    localparam int EW = (MW > 8) ? MW : 8;
    localparam int TW = MW + 4;

    // ------------------------------------------------------------------
    // Tight-path hits at residue slot d: the digits i < g with
    // (t + i) mod m == k, where d = (k - t) mod m. Small moduli wrap
    // the nine-digit run several times, hence the scan over n.
    // ------------------------------------------------------------------
    function automatic logic [3:0] tight_hits(input logic [AW-1:0]      d,
                                              input logic [DIGIT_W-1:0] g,
                                              input logic [MW-1:0]      m);
        logic [3:0]    acc;
        logic [TW-1:0] pos;
        acc = '0;
        for (int n = 0; n < 9; n++)
        begin
            pos = TW'(d) + TW'(n) * TW'(m);
            if (pos < TW'(g))
            begin
                acc = acc + 4'd1;
            end
        end
        return acc;
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t              state_reg,     state_next;
    logic [7:0]          modulus_reg,   modulus_next;
    logic [MW-1:0]       mod_eff_reg,   mod_eff_next;
    logic [3:0]          prep_cnt_reg,  prep_cnt_next;
    logic [DIGIT_W-1:0]  digit_reg,     digit_next;
    logic                last_reg,      last_next;
    logic [AW-1:0]       t_reg,         t_next;      // tight residue
    logic [AW-1:0]       tn_reg,        tn_next;     // tight residue after this digit
    logic [AW-1:0]       d_reg,         d_next;      // (k - t) mod m for write slot k
    logic [AW-1:0]       idx_reg,       idx_next;    // read residue
    logic [CW-1:0]       rd_cnt_reg,    rd_cnt_next;
    logic [AW-1:0]       wr_cnt_reg,    wr_cnt_next; // write residue k
    logic                cur_reg,       cur_next;    // bank holding the live table
    logic                fresh_reg,     fresh_next;  // table cleared, reads as zero
    logic                v1_reg,        v1_next;
    logic                p1_reg,        p1_next;
    logic                v2_reg,        v2_next;
    logic                p2_reg,        p2_next;
    logic                p3_reg,        p3_next;
    logic                out_valid_reg, out_valid_next;

    logic [CNT_W-1:0]    win_reg [WINDOW];
    logic [CNT_W-1:0]    win_next [WINDOW];
    logic [CNT_W-1:0]    delta_reg,     delta_next;
    logic [CNT_W-1:0]    sum_reg,       sum_next;
    logic [CNT_W-1:0]    n0_reg,        n0_next;     // new table entry 0
    logic [CNT_W-1:0]    out_data_reg,  out_data_next;

    // ------------------------------------------------------------------
    // Datapath signals
    // ------------------------------------------------------------------
    logic [AW-1:0]       mm1;
    logic [AW-1:0]       idx_inc, idx_dec, tn_inc, d_inc;
    logic [CW-1:0]       rd_total;
    logic                rd_issue;
    logic                wr_en;
    logic                wr_last;
    logic                out_load;
    logic                cfg_we;
    logic [EW-1:0]       cfg_mod;
    logic [DIGIT_W-1:0]  in_digit;
    logic [3:0]          hits;
    logic [CNT_W-1:0]    wdata;
    logic [CNT_W-1:0]    rdata0, rdata1;
    logic [CNT_W-1:0]    rd_val;
    logic [CNT_W-1:0]    result;

    // ------------------------------------------------------------------
    // Two table banks: the sweep reads the live bank and writes the
    // other one, then the roles swap.
    // ------------------------------------------------------------------
    dsdc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_MODULUS)
    ) u_bank0 (
        .clk   (clk),
        .we    (wr_en && cur_reg),
        .waddr (wr_cnt_reg),
        .wdata (wdata),
        .re    (rd_issue && !cur_reg),
        .raddr (idx_reg),
        .rdata (rdata0)
    );

    dsdc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_MODULUS)
    ) u_bank1 (
        .clk   (clk),
        .we    (wr_en && !cur_reg),
        .waddr (wr_cnt_reg),
        .wdata (wdata),
        .re    (rd_issue && cur_reg),
        .raddr (idx_reg),
        .rdata (rdata1)
    );

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == REG_MODULUS_ADDR);
    assign prdata = (paddr == REG_MODULUS_ADDR) ? {24'd0, modulus_reg} : 32'd0;

    // Zero acts as 1, anything above the table size as the table size.
    assign cfg_mod = EW'(pwdata[7:0]);

    // ------------------------------------------------------------------
    // Residue arithmetic, all modulo m
    // ------------------------------------------------------------------
    assign mm1     = AW'(mod_eff_reg - MW'(1));
    assign idx_inc = (idx_reg == mm1)   ? '0  : idx_reg + AW'(1);
    assign idx_dec = (idx_reg == '0)    ? mm1 : idx_reg - AW'(1);
    assign tn_inc  = (tn_reg == mm1)    ? '0  : tn_reg + AW'(1);
    assign d_inc   = (d_reg == mm1)     ? '0  : d_reg + AW'(1);

    // Reads run over j = -9 .. m-1; the window sum is valid from j = 0 on.
    assign rd_total = CW'(mod_eff_reg) + CW'(WINDOW - 1);
    assign rd_issue = (state_reg == ST_SWEEP) && (rd_cnt_reg != rd_total);

    assign wr_en   = p3_reg;
    assign wr_last = wr_en && (wr_cnt_reg == mm1);

    assign in_digit = (s_tdata[DIGIT_W-1:0] > TOP_DIGIT) ? TOP_DIGIT
                                                         : s_tdata[DIGIT_W-1:0];

    assign rd_val = fresh_reg ? '0 : (cur_reg ? rdata1 : rdata0);
    assign hits   = tight_hits(d_reg, digit_reg, mod_eff_reg);
    assign wdata  = add_mod(sum_reg, CNT_W'(hits));

    // Count = table[0] + (tight residue is 0) - 1 for the number zero.
    assign result = (t_reg == '0) ? n0_reg
                  : ((n0_reg == '0) ? COUNT_PRIME - CNT_W'(1) : n0_reg - CNT_W'(1));

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        modulus_next   = modulus_reg;
        mod_eff_next   = mod_eff_reg;
        prep_cnt_next  = prep_cnt_reg;
        digit_next     = digit_reg;
        last_next      = last_reg;
        t_next         = t_reg;
        tn_next        = tn_reg;
        d_next         = d_reg;
        idx_next       = idx_reg;
        rd_cnt_next    = rd_cnt_reg;
        wr_cnt_next    = wr_cnt_reg;
        cur_next       = cur_reg;
        fresh_next     = fresh_reg;
        n0_next        = n0_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_load       = 1'b0;

        // window pipeline: read -> difference -> running sum -> write
        v1_next    = rd_issue;
        p1_next    = rd_issue && (rd_cnt_reg >= CW'(WINDOW - 1));
        v2_next    = v1_reg;
        p2_next    = p1_reg;
        p3_next    = p2_reg;
        delta_next = delta_reg;
        sum_next   = sum_reg;
        for (int i = 0; i < WINDOW; i++)
        begin
            win_next[i] = win_reg[i];
        end

        if (v1_reg)
        begin
            delta_next  = sub_mod(rd_val, win_reg[WINDOW-1]);
            win_next[0] = rd_val;
            for (int i = 1; i < WINDOW; i++)
            begin
                win_next[i] = win_reg[i-1];
            end
        end
        if (v2_reg)
        begin
            sum_next = add_mod(sum_reg, delta_reg);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    digit_next    = in_digit;
                    last_next     = s_tlast;
                    prep_cnt_next = '0;
                    idx_next      = '0;
                    tn_next       = t_reg;
                    d_next        = (t_reg == '0) ? '0
                                                  : AW'(mod_eff_reg - MW'(t_reg));
                    sum_next      = '0;
                    for (int i = 0; i < WINDOW; i++)
                    begin
                        win_next[i] = '0;
                    end
                    state_next    = ST_PREP;
                end
            end

            ST_PREP:
            begin
                // step back nine residues for the window start, step the
                // tight residue forward by the digit
                idx_next = idx_dec;
                if (prep_cnt_reg < digit_reg)
                begin
                    tn_next = tn_inc;
                end
                prep_cnt_next = prep_cnt_reg + 4'd1;
                if (prep_cnt_reg == 4'(WINDOW - 2))
                begin
                    rd_cnt_next = '0;
                    state_next  = ST_SWEEP;
                end
            end

            ST_SWEEP:
            begin
                if (rd_issue)
                begin
                    idx_next    = idx_inc;
                    rd_cnt_next = rd_cnt_reg + CW'(1);
                end
                if (wr_en)
                begin
                    d_next      = d_inc;
                    wr_cnt_next = wr_cnt_reg + AW'(1);
                    if (wr_cnt_reg == '0)
                    begin
                        n0_next = wdata;
                    end
                end
                if (wr_last)
                begin
                    wr_cnt_next = '0;
                    cur_next    = !cur_reg;
                    fresh_next  = 1'b0;
                    t_next      = tn_reg;
                    state_next  = last_reg ? ST_OUT : ST_IDLE;
                end
            end

            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    out_data_next  = result;
                    fresh_next     = 1'b1;
                    t_next         = '0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // modulus write drops any partly entered bound
        if (cfg_we)
        begin
            modulus_next = pwdata[7:0];
            if (cfg_mod == '0)
            begin
                mod_eff_next = MW'(1);
            end
            else if (cfg_mod > EW'(MAX_MODULUS))
            begin
                mod_eff_next = MW'(MAX_MODULUS);
            end
            else
            begin
                mod_eff_next = MW'(cfg_mod);
            end
            fresh_next = 1'b1;
            t_next     = '0;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            modulus_reg   <= MODULUS_RESET;
            mod_eff_reg   <= MW'(1);
            prep_cnt_reg  <= '0;
            t_reg         <= '0;
            rd_cnt_reg    <= '0;
            wr_cnt_reg    <= '0;
            cur_reg       <= 1'b0;
            fresh_reg     <= 1'b1;
            v1_reg        <= 1'b0;
            p1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            p3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            modulus_reg   <= modulus_next;
            mod_eff_reg   <= mod_eff_next;
            prep_cnt_reg  <= prep_cnt_next;
            t_reg         <= t_next;
            rd_cnt_reg    <= rd_cnt_next;
            wr_cnt_reg    <= wr_cnt_next;
            cur_reg       <= cur_next;
            fresh_reg     <= fresh_next;
            v1_reg        <= v1_next;
            p1_reg        <= p1_next;
            v2_reg        <= v2_next;
            p2_reg        <= p2_next;
            p3_reg        <= p3_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        digit_reg    <= digit_next;
        last_reg     <= last_next;
        tn_reg       <= tn_next;
        d_reg        <= d_next;
        idx_reg      <= idx_next;
        delta_reg    <= delta_next;
        sum_reg      <= sum_next;
        n0_reg       <= n0_next;
        out_data_reg <= out_data_next;
        for (int i = 0; i < WINDOW; i++)
        begin
            win_reg[i] <= win_next[i];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `DSDC_ASSERT(a_wr_in_range, wr_en |-> (MW'(wr_cnt_reg) < mod_eff_reg), "table write beyond modulus")
    `DSDC_ASSERT(a_wr_in_sweep, (state_reg != ST_SWEEP) |-> (!p3_reg && !v1_reg), "pipeline busy outside sweep")
    `DSDC_ASSERT_ALWAYS(a_tight_range, MW'(t_reg) < mod_eff_reg, "tight residue not below modulus")
    `DSDC_ASSERT(a_load_on_last, out_load |-> last_reg, "result loaded for a digit not marked last")

endmodule

@@ bench/digit_sum_divisible_counter_tb.sv @@
`timescale 1ns / 1ps

module digit_sum_divisible_counter_tb;

    import dsdc_pkg::*;

    localparam int          MAX_MOD      = 128;
    localparam int          CLK_HALF     = 4;    // 8 ns period
    localparam int          RESET_CYCLES = 4;
    localparam int          SETTLE       = 200;  // outlasts one digit's sweep at m = 128
    localparam int          IDLE_PCT     = 38;
    localparam int          RANDOM_ITEMS = 950;
    localparam longint      PRIME        = longint'(COUNT_PRIME);

    // Scoreboard: forward digit DP over digit-sum residues, plus the queue of
    // counts still owed by the block.
    class count_scoreboard;
        bit [7:0]       modulus_reg;
        bit [CNT_W-1:0] below_counts [MAX_MOD];
        int unsigned    tight_residue;
        bit [CNT_W-1:0] expected_counts [$];
        int             mismatches;

        function new();
            mismatches = 0;
            load_modulus(MODULUS_RESET);
        endfunction

        // a register write also drops any partly entered bound
        function void load_modulus(bit [7:0] value);
            modulus_reg = value;
            foreach (below_counts[r])
            begin
                below_counts[r] = '0;
            end
            tight_residue = 0;
        endfunction

        function void note_digit(bit [DIGIT_W-1:0] digit, bit last_digit);
            longint      next_counts [MAX_MOD];
            int unsigned m;
            int unsigned g;
            int unsigned t;
            longint      c;

            m = (modulus_reg == 0) ? 1 : 32'(modulus_reg);
            if (m > MAX_MOD)
            begin
                m = MAX_MOD;
            end
            g = 32'((digit > TOP_DIGIT) ? TOP_DIGIT : digit);
            t = tight_residue % m;
            foreach (next_counts[r])
            begin
                next_counts[r] = 0;
            end
            // loose prefixes take any digit
            for (int unsigned r = 0; r < m; r++)
            begin
                for (int unsigned i = 0; i <= TOP_DIGIT; i++)
                begin
                    next_counts[(r + i) % m] = (next_counts[(r + i) % m] + below_counts[r]) % PRIME;
                end
            end
            // tight prefix drops below K on any smaller digit
            for (int unsigned i = 0; i < g; i++)
            begin
                next_counts[(t + i) % m] = (next_counts[(t + i) % m] + 1) % PRIME;
            end
            foreach (below_counts[r])
            begin
                below_counts[r] = next_counts[r][CNT_W-1:0];
            end
            tight_residue = (t + g) % m;

            if (last_digit)
            begin
                c = longint'(below_counts[0]);
                if (tight_residue == 0)
                begin
                    c = c + 1;
                end
                c = (c + PRIME - 1) % PRIME;    // minus one for zero, wrapped
                expected_counts.push_back(c[CNT_W-1:0]);
                load_modulus(modulus_reg);
            end
        endfunction

        function void check_count(bit [CNT_W-1:0] actual);
            bit [CNT_W-1:0] expected;

            if (expected_counts.size() == 0)
            begin
                $display("%0t: unexpected count, expected none, actual %0d", $time, actual);
                mismatches++;
            end
            else
            begin
                expected = expected_counts.pop_front();
                if (actual !== expected)
                begin
                    $display("%0t: count mismatch, expected %0d, actual %0d",
                             $time, expected, actual);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return expected_counts.size();
        endfunction
    endclass

    // DUT ports, all inputs known from time zero
    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // [3:0] digit, [7:4] zero
    logic        s_tlast = 1'b0;   // last_digit
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [29:0] count, [31:30] zero
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [1:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    count_scoreboard sb;
    int              idle_pct = IDLE_PCT;   // shared by both sides
    int              random_sent = 0;

    digit_sum_divisible_counter #(
        .MAX_MODULUS(MAX_MOD)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #CLK_HALF clk = ~clk;

    // Result side: values sampled here are the ones before this edge's
    // updates, so a transaction is checked exactly once at its accept edge.
    // Ready is re-rolled every cycle for random back-pressure.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                sb.check_count(m_tdata[CNT_W-1:0]);
            end
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // One digit transaction. Valid drops only on idle cycles, so back-to-back
    // digits never see a low/high pair of writes in the same step.
    task automatic send_digit(input logic [DIGIT_W-1:0] digit, input logic last_digit);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, digit};
        s_tlast  <= last_digit;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sb.note_digit(digit, last_digit);
    endtask

    // Mostly decimal digits; now and then an out-of-range nibble (read as 9).
    function automatic logic [DIGIT_W-1:0] pick_digit();
        if ($urandom_range(9) == 0)
        begin
            return DIGIT_W'($urandom_range(15, 10));
        end
        return DIGIT_W'($urandom_range(9));
    endfunction

    // Random bound of the given length; finish = 0 leaves it partly entered.
    task automatic send_bound(input int len, input bit finish);
        for (int i = 0; i < len; i++)
        begin
            idle_pct = (random_sent >= 300 && random_sent < 500) ? 0 : IDLE_PCT;
            send_digit(pick_digit(), finish && (i == len - 1));
            random_sent++;
        end
    endtask

    // Wait for every owed count, then let a non-last digit finish its sweep.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // APB write: setup then access; the register takes it at the access edge.
    task automatic write_modulus(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_MODULUS_ADDR;
        pwdata  <= {24'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.load_modulus(value);
    endtask

    initial
    begin
        logic [7:0] modulus;
        int         bounds;
        int         len;

        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part, modulus at its reset value of 1 ---
        send_digit(4'd0, 1'b1);                 // K = 0: nothing qualifies
        send_digit(4'd9, 1'b1);                 // single digit, top value
        send_digit(4'd0, 1'b0);                 // leading zeros
        send_digit(4'd0, 1'b0);
        send_digit(4'd1, 1'b0);
        send_digit(4'd5, 1'b1);
        send_digit(4'd15, 1'b0);                // nibbles above nine read as 9
        send_digit(4'd10, 1'b1);
        drain();
        write_modulus(8'd128);                  // largest modulus
        send_digit(4'd9, 1'b0);
        send_digit(4'd9, 1'b0);
        send_digit(4'd9, 1'b1);
        drain();
        write_modulus(8'd0);                    // zero modulus acts as 1
        send_digit(4'd12, 1'b0);
        send_digit(4'd7, 1'b1);
        drain();
        write_modulus(8'd255);                  // clamps to the table size
        send_digit(4'd3, 1'b1);
        drain();
        write_modulus(8'd3);
        send_digit(4'd4, 1'b0);                 // partial bound, dropped below
        send_digit(4'd5, 1'b0);
        drain();
        write_modulus(8'd3);
        send_digit(4'd2, 1'b0);
        send_digit(4'd0, 1'b1);

        // --- random part: phases of one modulus each ---
        while (random_sent < RANDOM_ITEMS)
        begin
            drain();
            case ($urandom_range(5))
                0: modulus = 8'd1;
                1: modulus = 8'd128;
                2: modulus = 8'd0;
                3: modulus = 8'd255;
                4: modulus = 8'($urandom_range(12, 2));
                default: modulus = 8'($urandom_range(255));
            endcase
            write_modulus(modulus);
            bounds = $urandom_range(5, 1);
            for (int b = 0; b < bounds; b++)
            begin
                // long bounds push counts past the prime and wrap
                len = ($urandom_range(9) == 0) ? $urandom_range(20, 10) : $urandom_range(8, 1);
                send_bound(len, 1'b1);
            end
            // now and then leave a bound half entered for the next write to drop
            if ($urandom_range(9) == 0)
            begin
                send_bound($urandom_range(4, 1), 1'b0);
            end
        end

        drain();
        if (sb.mismatches == 0)
        begin
            $display("PASS digit_sum_divisible_counter");
        end
        else
        begin
            $display("FAIL digit_sum_divisible_counter");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #6ms;
        $display("FAIL digit_sum_divisible_counter");
        $finish;
    end

endmodule
